@@ sv/fltb_pkg.sv @@
`timescale 1ns / 1ps

package fltb_pkg;

  // Table store geometry
  localparam int NUM_TABLES        = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int TBL_W             = $clog2(NUM_TABLES);
  localparam int CNT_W             = TBL_W + 1;
  localparam int MEM_DEPTH         = NUM_TABLES * ENTRIES_PER_TABLE;
  localparam int MEM_AW            = TBL_W + IDX_W;

  // Field widths
  localparam int ADDR_W     = 52;
  localparam int VA_W       = 48;
  localparam int PAGE_SHIFT = 12;
  localparam int VPN_W      = VA_W - PAGE_SHIFT;
  localparam int LVL_W      = 2;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROOT_TABLE = 1'b0,
    REG_POOL_BASE  = 1'b1
  } cfg_reg_t;

  // Controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_CHECK,
    S_LINK,
    S_LEAF,
    S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic rd;
    logic eval;
    logic link;
    logic leaf;
    logic set_fail;
    logic ld_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic present;
    logic bad_ptr;
    logic lvl_last;
    logic fits;
    logic no_alloc;
    logic out_busy;
  } dp_sts_t;

endpackage

@@ sv/fltb_ram.sv @@
`timescale 1ns / 1ps

module fltb_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/fltb_ctrl.sv @@
`timescale 1ns / 1ps

module fltb_ctrl import fltb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (!sts.present) begin
          state_nxt = S_CHECK;
        end else if (sts.bad_ptr) begin
          cmd.set_fail = 1'b1;
          state_nxt    = S_OUT;
        end else if (sts.lvl_last) begin
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_CHECK: begin
        if (!sts.fits) begin
          cmd.set_fail = 1'b1;
          state_nxt    = S_OUT;
        end else if (sts.no_alloc) begin
          state_nxt = S_LEAF;
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link = 1'b1;
        if (sts.lvl_last) begin
          state_nxt = S_LEAF;
        end
      end
      S_LEAF: begin
        cmd.leaf  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/fltb_dp.sv @@
`timescale 1ns / 1ps

module fltb_dp import fltb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  input  logic [ADDR_W-1:0]    in_phys_addr,
  input  logic [VA_W-1:0]      in_virt_addr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_W-1:0]    out_leaf_entry,
  output logic [1:0]           out_tables_added,
  output logic                 out_out_of_tables,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts
);

  logic [ADDR_W-1:0]     pool_r, pool_nxt;
  logic [ADDR_W-1:0]     pa_r, pa_nxt;
  logic [VPN_W-1:0]      vpn_r, vpn_nxt;
  logic [LVL_W-1:0]      lvl_r, lvl_nxt;
  logic [TBL_W-1:0]      cur_r, cur_nxt;
  logic [CNT_W-1:0]      nf_r, nf_nxt;
  logic [1:0]            needed_r, needed_nxt;
  logic                  fail_r, fail_nxt;
  logic [NUM_TABLES-1:0] tbl_valid_r, tbl_valid_nxt;
  logic [MEM_AW-1:0]     clr_r, clr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]     leaf_r, leaf_nxt;
  logic [1:0]            added_r, added_nxt;
  logic                  oot_r, oot_nxt;

  logic [IDX_W-1:0]      idx_cur;
  logic [IDX_W-1:0]      idx_leaf;
  logic [ADDR_W-1:0]     rdata;
  logic [ADDR_W-1:0]     entry;
  logic [ADDR_W-1:0]     diff;
  logic [TBL_W-1:0]      q;
  logic [TBL_W-1:0]      k;
  logic                  in_range;
  logic                  allocated;
  logic [ADDR_W-1:0]     new_tbl_addr;
  logic                  mem_we;
  logic [MEM_AW-1:0]     mem_addr;
  logic [ADDR_W-1:0]     mem_wdata;

  // Index for the current level
  always_comb begin
    case (lvl_r)
      2'd0:    idx_cur = vpn_r[4*IDX_W-1 -: IDX_W];
      2'd1:    idx_cur = vpn_r[3*IDX_W-1 -: IDX_W];
      2'd2:    idx_cur = vpn_r[2*IDX_W-1 -: IDX_W];
      default: idx_cur = vpn_r[IDX_W-1:0];
    endcase
  end
  assign idx_leaf = vpn_r[IDX_W-1:0];

  // Entry decode: tables never allocated read as zero
  assign entry = tbl_valid_r[cur_r] ? rdata : '0;
  assign diff  = {entry[ADDR_W-1:2], 2'b00} - {pool_r[ADDR_W-1:2], 2'b00};
  assign q     = diff[PAGE_SHIFT+TBL_W-1:PAGE_SHIFT];
  assign k     = q + 1'b1;

  assign in_range  = (diff[PAGE_SHIFT-1:0] == '0) &&
                     (diff[ADDR_W-1:PAGE_SHIFT+TBL_W] == '0) &&
                     (q < TBL_W'(NUM_TABLES - 1));
  assign allocated = (({1'b0, q} + 1'b1) < nf_r);

  // Address of the table handed out next
  assign new_tbl_addr = pool_r +
                        {(ADDR_W-PAGE_SHIFT)'(nf_r - 1'b1), {PAGE_SHIFT{1'b0}}};

  // Status back to the controller
  always_comb begin
    sts.clr_last = (clr_r == MEM_AW'(MEM_DEPTH - 1));
    sts.present  = entry[0];
    sts.bad_ptr  = !(in_range && allocated);
    sts.lvl_last = (lvl_r == 2'd2);
    sts.fits     = (({1'b0, nf_r} + (CNT_W+1)'(needed_r)) <= (CNT_W+1)'(NUM_TABLES));
    sts.no_alloc = (needed_r == 2'd0);
    sts.out_busy = out_valid_r && !out_ready;
  end

  // Table store port
  always_comb begin
    mem_we    = cmd.clr_step | cmd.link | cmd.leaf;
    mem_addr  = {cur_r, idx_cur};
    mem_wdata = {pa_r[ADDR_W-1:2], 2'b11};
    if (cmd.clr_step) begin
      mem_addr  = clr_r;
      mem_wdata = '0;
    end else if (cmd.link) begin
      mem_wdata = {new_tbl_addr[ADDR_W-1:2], 2'b11};
    end else if (cmd.leaf) begin
      mem_addr = {cur_r, idx_leaf};
    end
  end

  fltb_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rdata)
  );

  // Next-state logic
  always_comb begin
    pool_nxt      = pool_r;
    pa_nxt        = pa_r;
    vpn_nxt       = vpn_r;
    lvl_nxt       = lvl_r;
    cur_nxt       = cur_r;
    nf_nxt        = nf_r;
    needed_nxt    = needed_r;
    fail_nxt      = fail_r;
    tbl_valid_nxt = tbl_valid_r;
    clr_nxt       = clr_r;
    leaf_nxt      = leaf_r;
    added_nxt     = added_r;
    oot_nxt       = oot_r;
    out_valid_nxt = out_valid_r && !out_ready;

    // Config writes; the root always lives at table zero, so its address
    // never reaches an entry
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_ROOT_TABLE: pool_nxt = pool_r;
        REG_POOL_BASE:  pool_nxt = cfg_wdata;
        default:        pool_nxt = pool_r;
      endcase
    end

    if (cmd.clr_step) begin
      clr_nxt = clr_r + 1'b1;
    end

    if (cmd.load) begin
      pa_nxt     = in_phys_addr;
      vpn_nxt    = in_virt_addr[VA_W-1:PAGE_SHIFT];
      lvl_nxt    = '0;
      cur_nxt    = '0;
      needed_nxt = '0;
      fail_nxt   = 1'b0;
    end

    // Walk step: record how many tables are missing, or follow the pointer
    if (cmd.eval) begin
      if (!entry[0]) begin
        needed_nxt = 2'd3 - lvl_r;
      end else if (in_range && allocated) begin
        cur_nxt = k;
        lvl_nxt = lvl_r + 1'b1;
      end
    end

    // Allocate a fresh table and link it in
    if (cmd.link) begin
      tbl_valid_nxt[nf_r[TBL_W-1:0]] = 1'b1;
      cur_nxt = nf_r[TBL_W-1:0];
      nf_nxt  = nf_r + 1'b1;
      lvl_nxt = lvl_r + 1'b1;
    end

    if (cmd.set_fail) begin
      fail_nxt = 1'b1;
    end

    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
      oot_nxt       = fail_r;
      leaf_nxt      = fail_r ? '0 : {pa_r[ADDR_W-1:2], 2'b11};
      added_nxt     = fail_r ? 2'd0 : needed_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r      <= '0;
      nf_r        <= CNT_W'(1);
      tbl_valid_r <= NUM_TABLES'(1);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pool_r      <= pool_nxt;
      nf_r        <= nf_nxt;
      tbl_valid_r <= tbl_valid_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    pa_r     <= pa_nxt;
    vpn_r    <= vpn_nxt;
    lvl_r    <= lvl_nxt;
    cur_r    <= cur_nxt;
    needed_r <= needed_nxt;
    fail_r   <= fail_nxt;
    leaf_r   <= leaf_nxt;
    added_r  <= added_nxt;
    oot_r    <= oot_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_leaf_entry    = leaf_r;
  assign out_tables_added  = added_r;
  assign out_out_of_tables = oot_r;

endmodule

@@ sv/four_level_page_table_builder.sv @@
// Steps: a read and a decode step per level walked, a check step, a write per new
//   table, the leaf write and a result step; a stale pointer skips the check and
//   all writes.
// Flow: one item at a time; a stalled out_ready holds the block in its result step.
// Reset: synchronous, active low; the table store is then zeroed by a pass over all
//   NUM_TABLES * 512 entries (32768), during which no input transaction is taken.
`timescale 1ns / 1ps

module four_level_page_table_builder import fltb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADDR_W-1:0]    in_phys_addr,
  input  logic [VA_W-1:0]      in_virt_addr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_W-1:0]    out_leaf_entry,
  output logic [1:0]           out_tables_added,
  output logic                 out_out_of_tables
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fltb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fltb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_phys_addr      (in_phys_addr),
    .in_virt_addr      (in_virt_addr),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_leaf_entry    (out_leaf_entry),
    .out_tables_added  (out_tables_added),
    .out_out_of_tables (out_out_of_tables),
    .cmd               (cmd),
    .sts               (sts)
  );

  // Busy after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a walk is running");

  // A failed mapping reports nothing else
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_tables |-> out_leaf_entry == '0 && out_tables_added == 2'd0)
    else $error("failed mapping carries a leaf or table count");

  // A good mapping carries the present and writable flags
  a_leaf_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_tables |-> out_leaf_entry[1:0] == 2'b11)
    else $error("leaf entry missing flag bits");

  // A loaded result only follows a completed walk, never a new transaction
  a_out_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule
